// File: design/rht_pkg.sv
// Shared types and constants for the reflection hit test pipeline.
// No dependencies; every stage module imports this package.
`default_nettype none

package rht_pkg;

    // Control that travels with each word down the pipeline
    typedef struct packed {
        logic valid;
        logic degenerate;
    } rht_tag_t;

    // The mirror formula scales v.N by two: applied as a left shift
    localparam int unsigned MIRROR_SHIFT = 1;

endpackage

`default_nettype wire

// File: design/rht_diff_stage.sv
// Stage 1: coordinate differences, segment normal and zero-length detection.
// Depends on rht_pkg for the pipeline tag type.
`default_nettype none

module rht_diff_stage #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [COORD_BITS-1:0]  sx,
    input  wire logic signed [COORD_BITS-1:0]  sy,
    input  wire logic signed [COORD_BITS-1:0]  ex,
    input  wire logic signed [COORD_BITS-1:0]  ey,
    input  wire logic signed [COORD_BITS-1:0]  ox,
    input  wire logic signed [COORD_BITS-1:0]  oy,
    input  wire logic signed [COORD_BITS-1:0]  tx,
    input  wire logic signed [COORD_BITS-1:0]  ty,
    output rht_pkg::rht_tag_t                  out_tag,
    input  wire logic                          out_ready,
    output logic signed [COORD_BITS:0]         nx,
    output logic signed [COORD_BITS:0]         ny,
    output logic signed [COORD_BITS:0]         vx [2],
    output logic signed [COORD_BITS:0]         vy [2],
    output logic signed [COORD_BITS:0]         dtx [2],
    output logic signed [COORD_BITS:0]         dty [2]
);
    import rht_pkg::*;

    localparam int D = COORD_BITS + 1;

    rht_tag_t tag_reg, tag_next;
    logic signed [D-1:0] nx_reg, nx_next, ny_reg, ny_next;
    logic signed [D-1:0] vx_reg [2];
    logic signed [D-1:0] vx_next [2];
    logic signed [D-1:0] vy_reg [2];
    logic signed [D-1:0] vy_next [2];
    logic signed [D-1:0] tx_reg [2];
    logic signed [D-1:0] tx_next [2];
    logic signed [D-1:0] ty_reg [2];
    logic signed [D-1:0] ty_next [2];

    assign in_ready = !tag_reg.valid || out_ready;

    always_comb
    begin
        tag_next.valid      = in_valid;
        tag_next.degenerate = (sx == ex) && (sy == ey);
        // N = (d.y, -d.x) with d = E - S
        nx_next    = D'(ey) - D'(sy);
        ny_next    = D'(sx) - D'(ex);
        // corner 0 works from S, corner 1 from E
        vx_next[0] = D'(ox) - D'(sx);
        vy_next[0] = D'(oy) - D'(sy);
        tx_next[0] = D'(tx) - D'(sx);
        ty_next[0] = D'(ty) - D'(sy);
        vx_next[1] = D'(ox) - D'(ex);
        vy_next[1] = D'(oy) - D'(ey);
        tx_next[1] = D'(tx) - D'(ex);
        ty_next[1] = D'(ty) - D'(ey);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else if (in_ready)
        begin
            tag_reg <= tag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            nx_reg <= nx_next;
            ny_reg <= ny_next;
            vx_reg <= vx_next;
            vy_reg <= vy_next;
            tx_reg <= tx_next;
            ty_reg <= ty_next;
        end
    end

    assign out_tag = tag_reg;
    assign nx      = nx_reg;
    assign ny      = ny_reg;
    assign vx      = vx_reg;
    assign vy      = vy_reg;
    assign dtx     = tx_reg;
    assign dty     = ty_reg;

endmodule

`default_nettype wire

// File: design/rht_prod_stage.sv
// Stage 2: dot and cross products of the differences with the normal.
// Depends on rht_pkg for the pipeline tag and the mirror scale shift.
`default_nettype none

module rht_prod_stage #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire rht_pkg::rht_tag_t               in_tag,
    output logic                                 in_ready,
    input  wire logic signed [COORD_BITS:0]      nx,
    input  wire logic signed [COORD_BITS:0]      ny,
    input  wire logic signed [COORD_BITS:0]      vx [2],
    input  wire logic signed [COORD_BITS:0]      vy [2],
    input  wire logic signed [COORD_BITS:0]      dtx [2],
    input  wire logic signed [COORD_BITS:0]      dty [2],
    output rht_pkg::rht_tag_t                    out_tag,
    input  wire logic                            out_ready,
    output logic signed [2*COORD_BITS+3:0]       nn,
    output logic signed [2*COORD_BITS+3:0]       am [2],
    output logic signed [2*COORD_BITS+3:0]       cn [2],
    output logic signed [2*COORD_BITS+3:0]       cv [2]
);
    import rht_pkg::*;

    localparam int D = COORD_BITS + 1;
    localparam int P = 2 * COORD_BITS + 4;

    rht_tag_t tag_reg;
    logic signed [2*D-1:0] p_nn0, p_nn1;
    logic signed [2*D-1:0] p_vn0 [2];
    logic signed [2*D-1:0] p_vn1 [2];
    logic signed [2*D-1:0] p_cn0 [2];
    logic signed [2*D-1:0] p_cn1 [2];
    logic signed [2*D-1:0] p_cv0 [2];
    logic signed [2*D-1:0] p_cv1 [2];
    logic signed [P-1:0]   nn_reg, nn_next;
    logic signed [P-1:0]   am_reg [2];
    logic signed [P-1:0]   am_next [2];
    logic signed [P-1:0]   cn_reg [2];
    logic signed [P-1:0]   cn_next [2];
    logic signed [P-1:0]   cv_reg [2];
    logic signed [P-1:0]   cv_next [2];

    assign in_ready = !tag_reg.valid || out_ready;

    always_comb
    begin
        p_nn0   = nx * nx;
        p_nn1   = ny * ny;
        nn_next = P'(p_nn0) + P'(p_nn1);
        for (int c = 0; c < 2; c++)
        begin
            p_vn0[c]   = vx[c] * nx;
            p_vn1[c]   = vy[c] * ny;
            p_cn0[c]   = dtx[c] * ny;
            p_cn1[c]   = dty[c] * nx;
            p_cv0[c]   = dtx[c] * vy[c];
            p_cv1[c]   = dty[c] * vx[c];
            // 2 * (v.N)
            am_next[c] = (P'(p_vn0[c]) + P'(p_vn1[c])) <<< MIRROR_SHIFT;
            cn_next[c] = P'(p_cn0[c]) - P'(p_cn1[c]);
            cv_next[c] = P'(p_cv0[c]) - P'(p_cv1[c]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else if (in_ready)
        begin
            tag_reg <= in_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_tag.valid)
        begin
            nn_reg <= nn_next;
            am_reg <= am_next;
            cn_reg <= cn_next;
            cv_reg <= cv_next;
        end
    end

    assign out_tag = tag_reg;
    assign nn      = nn_reg;
    assign am      = am_reg;
    assign cn      = cn_reg;
    assign cv      = cv_reg;

endmodule

`default_nettype wire

// File: design/rht_part_stage.sv
// Stage 3: partial products of the two wide products of each corner.
// Each operand splits into a signed high half and an unsigned low half.
// Depends on rht_pkg for the pipeline tag type.
`default_nettype none

module rht_part_stage #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire rht_pkg::rht_tag_t               in_tag,
    output logic                                 in_ready,
    input  wire logic signed [2*COORD_BITS+3:0]  nn,
    input  wire logic signed [2*COORD_BITS+3:0]  am [2],
    input  wire logic signed [2*COORD_BITS+3:0]  cn [2],
    input  wire logic signed [2*COORD_BITS+3:0]  cv [2],
    output rht_pkg::rht_tag_t                    out_tag,
    input  wire logic                            out_ready,
    output logic signed [2*COORD_BITS+5:0]       pp [2][2][4]
);
    import rht_pkg::*;

    localparam int P = 2 * COORD_BITS + 4;
    localparam int L = P / 2;
    localparam int K = L + 1;
    localparam int Q = 2 * K;

    rht_tag_t tag_reg;
    logic signed [P-1:0] op_x [2][2];
    logic signed [P-1:0] op_y [2][2];
    logic signed [K-1:0] xh [2][2];
    logic signed [K-1:0] xl [2][2];
    logic signed [K-1:0] yh [2][2];
    logic signed [K-1:0] yl [2][2];
    logic signed [Q-1:0] pp_reg [2][2][4];
    logic signed [Q-1:0] pp_next [2][2][4];

    assign in_ready = !tag_reg.valid || out_ready;

    always_comb
    begin
        for (int c = 0; c < 2; c++)
        begin
            // product 0 is 2(v.N) * cross(t, N), product 1 is N.N * cross(t, v)
            op_x[c][0] = am[c];
            op_y[c][0] = cn[c];
            op_x[c][1] = nn;
            op_y[c][1] = cv[c];
            for (int k = 0; k < 2; k++)
            begin
                xh[c][k] = K'(signed'(op_x[c][k][P-1:L]));
                xl[c][k] = K'(op_x[c][k][L-1:0]);
                yh[c][k] = K'(signed'(op_y[c][k][P-1:L]));
                yl[c][k] = K'(op_y[c][k][L-1:0]);
                pp_next[c][k][0] = xh[c][k] * yh[c][k];
                pp_next[c][k][1] = xh[c][k] * yl[c][k];
                pp_next[c][k][2] = xl[c][k] * yh[c][k];
                pp_next[c][k][3] = xl[c][k] * yl[c][k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else if (in_ready)
        begin
            tag_reg <= in_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_tag.valid)
        begin
            pp_reg <= pp_next;
        end
    end

    assign out_tag = tag_reg;
    assign pp      = pp_reg;

endmodule

`default_nettype wire

// File: design/rht_sum_stage.sv
// Stage 4: recombine the partial products into the full wide products.
// Depends on rht_pkg for the pipeline tag type.
`default_nettype none

module rht_sum_stage #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire rht_pkg::rht_tag_t               in_tag,
    output logic                                 in_ready,
    input  wire logic signed [2*COORD_BITS+5:0]  pp [2][2][4],
    output rht_pkg::rht_tag_t                    out_tag,
    input  wire logic                            out_ready,
    output logic signed [4*COORD_BITS+7:0]       prod [2][2]
);
    import rht_pkg::*;

    localparam int P = 2 * COORD_BITS + 4;
    localparam int L = P / 2;
    localparam int R = 2 * P;

    rht_tag_t tag_reg;
    logic signed [R-1:0] prod_reg [2][2];
    logic signed [R-1:0] prod_next [2][2];

    assign in_ready = !tag_reg.valid || out_ready;

    always_comb
    begin
        for (int c = 0; c < 2; c++)
        begin
            for (int k = 0; k < 2; k++)
            begin
                prod_next[c][k] = (R'(pp[c][k][0]) <<< (2 * L))
                                + ((R'(pp[c][k][1]) + R'(pp[c][k][2])) <<< L)
                                + R'(pp[c][k][3]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else if (in_ready)
        begin
            tag_reg <= in_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_tag.valid)
        begin
            prod_reg <= prod_next;
        end
    end

    assign out_tag = tag_reg;
    assign prod    = prod_reg;

endmodule

`default_nettype wire

// File: design/reflection_hit_test.sv
// Reflection hit test: decides whether a shot from an origin can ricochet off
// one mirror segment onto a target.
// Input channel (in_valid/in_ready) takes one word per cycle while in_ready is high:
// segment start, segment end, origin and target, each COORD_BITS signed. Output channel
// (out_valid/out_ready) returns one word per input: can_hit and degenerate.
// Pipeline: each word passes five register stages: differences, products with
// the normal, split partial products, product recombination, and the sign
// compare with output register; the accepting edge loads the first of them.
// Throughput is one word per cycle; each stage accepts while the next is free
// or its own register is empty, so a stall on out_ready fills the stages and
// then drops in_ready without losing or repeating any word.
// A zero-length segment reports degenerate = 1 and can_hit = 0.
// Reset empties every stage; the block keeps no state between words.
// Depends on rht_pkg and the four stage modules.
`default_nettype none

module reflection_hit_test #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [COORD_BITS-1:0]  edge_start_x,
    input  wire logic signed [COORD_BITS-1:0]  edge_start_y,
    input  wire logic signed [COORD_BITS-1:0]  edge_end_x,
    input  wire logic signed [COORD_BITS-1:0]  edge_end_y,
    input  wire logic signed [COORD_BITS-1:0]  origin_x,
    input  wire logic signed [COORD_BITS-1:0]  origin_y,
    input  wire logic signed [COORD_BITS-1:0]  target_x,
    input  wire logic signed [COORD_BITS-1:0]  target_y,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               can_hit,
    output logic                               degenerate
);
    import rht_pkg::*;

    localparam int D = COORD_BITS + 1;
    localparam int P = 2 * COORD_BITS + 4;
    localparam int Q = P + 2;
    localparam int R = 2 * P;

    rht_tag_t tag1, tag2, tag3, tag4;
    logic     rdy2, rdy3, rdy4, rdy5;

    logic signed [D-1:0] nx, ny;
    logic signed [D-1:0] vx [2];
    logic signed [D-1:0] vy [2];
    logic signed [D-1:0] dtx [2];
    logic signed [D-1:0] dty [2];
    logic signed [P-1:0] nn;
    logic signed [P-1:0] am [2];
    logic signed [P-1:0] cn [2];
    logic signed [P-1:0] cv [2];
    logic signed [Q-1:0] pp [2][2][4];
    logic signed [R-1:0] prod [2][2];

    logic signed [R:0] diff [2];
    logic              neg [2];
    logic              pos [2];
    rht_tag_t          tag_reg;
    logic              can_hit_reg, can_hit_next;

    rht_diff_stage #(.COORD_BITS(COORD_BITS)) u_diff (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sx        (edge_start_x),
        .sy        (edge_start_y),
        .ex        (edge_end_x),
        .ey        (edge_end_y),
        .ox        (origin_x),
        .oy        (origin_y),
        .tx        (target_x),
        .ty        (target_y),
        .out_tag   (tag1),
        .out_ready (rdy2),
        .nx        (nx),
        .ny        (ny),
        .vx        (vx),
        .vy        (vy),
        .dtx       (dtx),
        .dty       (dty)
    );

    rht_prod_stage #(.COORD_BITS(COORD_BITS)) u_prod (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_tag    (tag1),
        .in_ready  (rdy2),
        .nx        (nx),
        .ny        (ny),
        .vx        (vx),
        .vy        (vy),
        .dtx       (dtx),
        .dty       (dty),
        .out_tag   (tag2),
        .out_ready (rdy3),
        .nn        (nn),
        .am        (am),
        .cn        (cn),
        .cv        (cv)
    );

    rht_part_stage #(.COORD_BITS(COORD_BITS)) u_part (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_tag    (tag2),
        .in_ready  (rdy3),
        .nn        (nn),
        .am        (am),
        .cn        (cn),
        .cv        (cv),
        .out_tag   (tag3),
        .out_ready (rdy4),
        .pp        (pp)
    );

    rht_sum_stage #(.COORD_BITS(COORD_BITS)) u_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_tag    (tag3),
        .in_ready  (rdy4),
        .pp        (pp),
        .out_tag   (tag4),
        .out_ready (rdy5),
        .prod      (prod)
    );

    assign rdy5 = !tag_reg.valid || out_ready;

    // Sign of N.N * cross(t, m) for each corner, then strict opposite signs
    always_comb
    begin
        for (int c = 0; c < 2; c++)
        begin
            diff[c] = (R + 1)'(prod[c][0]) - (R + 1)'(prod[c][1]);
            neg[c]  = diff[c][R];
            pos[c]  = !diff[c][R] && (diff[c] != '0);
        end
        can_hit_next = !tag4.degenerate
                     && ((neg[0] && pos[1]) || (pos[0] && neg[1]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else if (rdy5)
        begin
            tag_reg <= tag4;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy5 && tag4.valid)
        begin
            can_hit_reg <= can_hit_next;
        end
    end

    assign out_valid  = tag_reg.valid;
    assign can_hit    = can_hit_reg;
    assign degenerate = tag_reg.degenerate;

endmodule

`default_nettype wire
